// ----- rtl/core/lsbp_pkg.sv -----
`default_nettype none

package lsbp_pkg;

  localparam int CodeFieldBits = 16;
  localparam int SymbolBits    = 8;
  localparam int ByteBits      = 8;
  localparam int PendBits      = ByteBits - 1;
  localparam int MaxCodeBits   = 16;
  localparam int CodeLimit     = (MaxCodeBits < CodeFieldBits) ? MaxCodeBits : CodeFieldBits;
  localparam int MaxBytes      = 3;
  localparam int AccBits       = PendBits + CodeFieldBits + SymbolBits;
  localparam int QueueDepth    = 2;

  typedef enum logic {
    CMD_APPEND = 1'b0,
    CMD_FLUSH  = 1'b1
  } cmd_t;

  typedef logic [1:0] byte_cnt_t;

  typedef struct packed {
    logic [MaxBytes*ByteBits-1:0] data;
    byte_cnt_t                    nbytes;
  } pack_entry_t;

endpackage

`default_nettype wire

// ----- rtl/core/lsbp_if.sv -----
`default_nettype none

interface lsbp_in_if;
  logic        valid;
  logic        ready;
  logic        command;
  logic [15:0] code_value;
  logic [7:0]  symbol_value;
  logic [4:0]  code_bits;

  modport source (output valid, output command, output code_value, output symbol_value,
                  output code_bits, input ready);
  modport sink   (input valid, input command, input code_value, input symbol_value,
                  input code_bits, output ready);
endinterface

interface lsbp_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last;

  modport source (output valid, output out_byte, output last, input ready);
  modport sink   (input valid, input out_byte, input last, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/lsb_first_code_symbol_packer_unit.sv -----
// channel | dir | handshake         | payload
// in_ch   | in  | valid/ready       | command, code_value, symbol_value, code_bits
// out_ch  | out | valid/ready       | out_byte, last
//
// an item is taken whenever the two-entry queue has room; the front
// merges it with the pending bits and queues 0 to 3 completed bytes
// the back sends one byte per cycle from a register while out_ch.ready is high, so a pair
// yields 1 to 3 bytes; a sustained stream runs at the byte rate of the output port
// synchronous active-low reset clears the pending bits, the queue and the back stage
// a stalled output fills the queue, after which in_ch.ready drops
`default_nettype none

module lsb_first_code_symbol_packer_unit (
  input  logic        clk,
  input  logic        rst_n,
  lsbp_in_if.sink     in_ch,
  lsbp_out_if.source  out_ch
);
  import lsbp_pkg::*;

  logic        push_valid;
  pack_entry_t push_entry;
  logic        q_full;
  logic        pop;
  logic        head_valid;
  pack_entry_t head_entry;

  lsbp_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .push_valid (push_valid),
    .push_entry (push_entry),
    .q_full     (q_full)
  );

  lsbp_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push_valid),
    .push_entry (push_entry),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_entry (head_entry)
  );

  lsbp_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head_entry (head_entry),
    .pop        (pop),
    .out_ch     (out_ch)
  );

endmodule

`default_nettype wire

// ----- rtl/core/lsbp_front.sv -----
`default_nettype none

module lsbp_front (
  input  logic                 clk,
  input  logic                 rst_n,
  lsbp_in_if.sink              in_ch,
  output logic                 push_valid,
  output lsbp_pkg::pack_entry_t push_entry,
  input  logic                 q_full
);
  import lsbp_pkg::*;

  logic [PendBits-1:0]      pend_bits_r, pend_bits_nxt;
  logic [2:0]               pend_cnt_r, pend_cnt_nxt;
  logic                     accept;
  logic [4:0]               nbits;
  logic [CodeFieldBits:0]   mask_w;
  logic [CodeFieldBits-1:0] code_m;
  logic [4:0]               total;
  logic [4:0]               total8;
  logic [AccBits-1:0]       acc;
  logic [AccBits-1:0]       rest;
  byte_cnt_t                nb;

  assign in_ch.ready = !q_full;
  assign accept      = in_ch.valid && !q_full;

  always_comb begin
    nbits  = (in_ch.code_bits > 5'(CodeLimit)) ? 5'(CodeLimit) : in_ch.code_bits;
    mask_w = ((CodeFieldBits+1)'(1) << nbits) - (CodeFieldBits+1)'(1);
    code_m = in_ch.code_value & mask_w[CodeFieldBits-1:0];
    total  = 5'(pend_cnt_r) + nbits;
    acc    = AccBits'(pend_bits_r)
           | (AccBits'(code_m) << pend_cnt_r)
           | (AccBits'(in_ch.symbol_value) << total);
    total8 = total + 5'(SymbolBits);
    // whole bytes completed by this pair
    nb     = total8[4:3];
    rest   = acc >> {nb, 3'b000};

    push_valid    = 1'b0;
    push_entry    = '0;
    pend_bits_nxt = pend_bits_r;
    pend_cnt_nxt  = pend_cnt_r;
    if (accept) begin
      if (in_ch.command == CMD_FLUSH) begin
        if (pend_cnt_r != 3'd0) begin
          push_valid        = 1'b1;
          push_entry.data   = (MaxBytes*ByteBits)'(pend_bits_r);
          push_entry.nbytes = 2'd1;
        end
        pend_bits_nxt = '0;
        pend_cnt_nxt  = 3'd0;
      end else begin
        push_valid        = (nb != 2'd0);
        push_entry.data   = acc[MaxBytes*ByteBits-1:0];
        push_entry.nbytes = nb;
        pend_bits_nxt     = rest[PendBits-1:0];
        pend_cnt_nxt      = total8[2:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_bits_r <= '0;
      pend_cnt_r  <= 3'd0;
    end else begin
      pend_bits_r <= pend_bits_nxt;
      pend_cnt_r  <= pend_cnt_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/lsbp_queue.sv -----
`default_nettype none

module lsbp_queue (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  lsbp_pkg::pack_entry_t push_entry,
  output logic                  full,
  input  logic                  pop,
  output logic                  head_valid,
  output lsbp_pkg::pack_entry_t head_entry
);
  import lsbp_pkg::*;

  localparam int PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int CntW = $clog2(QueueDepth + 1);

  pack_entry_t     mem_r [QueueDepth];
  logic [PtrW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PtrW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CntW-1:0] cnt_r, cnt_nxt;
  logic            do_push, do_pop;

  assign full       = (cnt_r == CntW'(QueueDepth));
  assign head_valid = (cnt_r != '0);
  assign head_entry = mem_r[rd_ptr_r];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr_r + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr_r + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + CntW'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - CntW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/lsbp_back.sv -----
`default_nettype none

module lsbp_back (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  head_valid,
  input  lsbp_pkg::pack_entry_t head_entry,
  output logic                  pop,
  lsbp_out_if.source            out_ch
);
  import lsbp_pkg::*;

  logic                         busy_r, busy_nxt;
  logic [MaxBytes*ByteBits-1:0] data_r, data_nxt;
  byte_cnt_t                    cnt_r, cnt_nxt;
  logic                         take;
  logic                         free;

  assign out_ch.valid    = busy_r;
  assign out_ch.out_byte = data_r[ByteBits-1:0];
  assign out_ch.last     = (cnt_r == 2'd1);

  assign take = busy_r && out_ch.ready;
  // slot frees when idle or when the final byte of the item leaves
  assign free = !busy_r || (take && cnt_r == 2'd1);
  assign pop  = free && head_valid;

  always_comb begin
    busy_nxt = busy_r;
    data_nxt = data_r;
    cnt_nxt  = cnt_r;
    if (pop) begin
      busy_nxt = 1'b1;
      data_nxt = head_entry.data;
      cnt_nxt  = head_entry.nbytes;
    end else if (free) begin
      busy_nxt = 1'b0;
      cnt_nxt  = 2'd0;
    end else if (take) begin
      data_nxt = data_r >> ByteBits;
      cnt_nxt  = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- verif/lsb_first_code_symbol_packer_unit_test.sv -----
`default_nettype none

module lsb_first_code_symbol_packer_unit_test;
  import lsbp_pkg::*;

  localparam int ClkHalf    = 4;
  localparam int CycleLimit = 400000;
  localparam int DrainSlack = 20;
  localparam int RandItems  = 160;
  localparam int SteadyItems = 40;

  typedef struct {
    logic [7:0] data;
    logic       last;
  } packed_byte_t;

  logic clk;
  logic rst_n;

  lsbp_in_if  in_ch ();
  lsbp_out_if out_ch ();

  lsb_first_code_symbol_packer_unit u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // own copy of the packer state
  logic [6:0]   pack_bits;
  logic [2:0]   pack_count;
  packed_byte_t due_bytes[$];

  int  err_count;
  int  bytes_checked;
  int  pair_count;
  int  flush_count;
  int  saturated_count;
  int  cycle_count;
  bit  send_gaps;
  bit  recv_stalls;

  initial begin
    clk = 1'b0;
    forever #ClkHalf clk = ~clk;
  end

  function automatic void pack_item(input cmd_t cmd, input logic [15:0] code,
                                    input logic [7:0] sym, input logic [4:0] nbits);
    logic [63:0]  acc;
    logic [31:0]  code_masked;
    int unsigned  n;
    int unsigned  total;
    packed_byte_t b;
    if (cmd == CMD_FLUSH) begin
      if (pack_count != 0) begin
        b.data = {1'b0, pack_bits};
        b.last = 1'b1;
        due_bytes.push_back(b);
      end
      pack_bits  = '0;
      pack_count = '0;
      return;
    end
    n = nbits;
    if (n > CodeLimit) n = CodeLimit;
    code_masked = {16'h0, code} & ((32'h1 << n) - 32'h1);
    acc   = {57'h0, pack_bits} | ({32'h0, code_masked} << pack_count);
    total = pack_count + n;
    acc   = acc | ({56'h0, sym} << total);
    total = total + SymbolBits;
    while (total >= ByteBits) begin
      b.data = acc[7:0];
      b.last = (total < 2 * ByteBits);
      due_bytes.push_back(b);
      acc   = acc >> ByteBits;
      total = total - ByteBits;
    end
    pack_count = total[2:0];
    pack_bits  = acc[6:0];
  endfunction

  // inputs are predicted before outputs are checked at the same edge
  always @(posedge clk) begin
    packed_byte_t exp_b;
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) begin
        if (cmd_t'(in_ch.command) == CMD_FLUSH) flush_count++;
        else begin
          pair_count++;
          if (in_ch.code_bits > CodeLimit) saturated_count++;
        end
        pack_item(cmd_t'(in_ch.command), in_ch.code_value, in_ch.symbol_value,
                  in_ch.code_bits);
      end
      if (out_ch.valid && out_ch.ready) begin
        bytes_checked++;
        if (due_bytes.size() == 0) begin
          err_count++;
          if (err_count <= 10)
            $display("unexpected byte %h last %b", out_ch.out_byte, out_ch.last);
        end else begin
          exp_b = due_bytes.pop_front();
          if (out_ch.out_byte !== exp_b.data || out_ch.last !== exp_b.last) begin
            err_count++;
            if (err_count <= 10)
              $display("byte mismatch: expected %h last %b, got %h last %b",
                       exp_b.data, exp_b.last, out_ch.out_byte, out_ch.last);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("timeout with %0d bytes outstanding", due_bytes.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  // receiver back-pressure in bursts
  initial begin
    out_ch.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (recv_stalls && $urandom_range(0, 5) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 17)) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
    end
  end

  task automatic send_item(input cmd_t cmd, input logic [15:0] code,
                           input logic [7:0] sym, input logic [4:0] nbits);
    in_ch.valid        <= 1'b1;
    in_ch.command      <= cmd;
    in_ch.code_value   <= code;
    in_ch.symbol_value <= sym;
    in_ch.code_bits    <= nbits;
    do @(posedge clk); while (!in_ch.ready);
    if (send_gaps && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
  endtask

  task automatic wait_for_drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (due_bytes.size() != 0) @(posedge clk);
    repeat (DrainSlack) @(posedge clk);
  endtask

  task automatic send_random_item();
    cmd_t        cmd;
    logic [4:0]  nbits;
    int unsigned pick;
    cmd  = ($urandom_range(0, 7) == 0) ? CMD_FLUSH : CMD_APPEND;
    pick = $urandom_range(0, 19);
    if (pick == 0)      nbits = 5'd0;
    else if (pick == 1) nbits = 5'd16;
    else if (pick < 4)  nbits = 5'($urandom_range(17, 31));
    else                nbits = 5'($urandom_range(0, 16));
    send_item(cmd, 16'($urandom), 8'($urandom), nbits);
  endtask

  task automatic test_field_extremes();
    send_item(CMD_APPEND, 16'hFFFF, 8'hFF, 5'd16);
    send_item(CMD_APPEND, 16'h0000, 8'h00, 5'd0);
    // code widths past the field saturate to 16
    send_item(CMD_APPEND, 16'hA5A5, 8'h3C, 5'd31);
    send_item(CMD_APPEND, 16'hFFFF, 8'h00, 5'd17);
    send_item(CMD_APPEND, 16'h5A5A, 8'hC3, 5'd1);
    // reach seven pending bits, then the widest pair on top of them
    send_item(CMD_APPEND, 16'hFFC0, 8'h81, 5'd6);
    send_item(CMD_APPEND, 16'hFFFF, 8'hFF, 5'd16);
    send_item(CMD_FLUSH, 16'h0000, 8'h00, 5'd0);
    send_item(CMD_APPEND, 16'h8001, 8'h7E, 5'd15);
    send_item(CMD_FLUSH, 16'hFFFF, 8'hFF, 5'd31);
  endtask

  task automatic test_flush_handling();
    // nothing pending: no byte
    send_item(CMD_FLUSH, 16'hFFFF, 8'hFF, 5'd31);
    send_item(CMD_APPEND, 16'h0005, 8'hA5, 5'd3);
    send_item(CMD_FLUSH, 16'h1234, 8'h56, 5'd9);
    send_item(CMD_FLUSH, 16'h0000, 8'h00, 5'd0);
    send_item(CMD_APPEND, 16'hFFFF, 8'h80, 5'd0);
    send_item(CMD_FLUSH, 16'h0000, 8'h00, 5'd0);
    send_item(CMD_APPEND, 16'h0001, 8'h01, 5'd8);
    send_item(CMD_APPEND, 16'h3FFF, 8'hFE, 5'd14);
    send_item(CMD_FLUSH, 16'h0000, 8'h00, 5'd0);
  endtask

  task automatic test_random_pairs();
    for (int i = 0; i < RandItems; i++) begin
      send_random_item();
      if (i == RandItems / 2) wait_for_drain();
    end
  endtask

  task automatic test_steady_stream();
    send_gaps   = 1'b0;
    recv_stalls = 1'b0;
    for (int i = 0; i < SteadyItems; i++) send_random_item();
  endtask

  initial begin
    pack_bits       = '0;
    pack_count      = '0;
    err_count       = 0;
    bytes_checked   = 0;
    pair_count      = 0;
    flush_count     = 0;
    saturated_count = 0;
    cycle_count     = 0;
    send_gaps       = 1'b1;
    recv_stalls     = 1'b1;
    rst_n              <= 1'b0;
    in_ch.valid        <= 1'b0;
    in_ch.command      <= CMD_APPEND;
    in_ch.code_value   <= '0;
    in_ch.symbol_value <= '0;
    in_ch.code_bits    <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_field_extremes();
    test_flush_handling();
    test_random_pairs();
    test_steady_stream();
    wait_for_drain();

    $display("covered %0d code/symbol pairs (%0d with oversized widths) and %0d flushes",
             pair_count, saturated_count, flush_count);
    $display("%0d packed bytes compared, %0d mismatches", bytes_checked, err_count);
    if (err_count == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

endmodule

`default_nettype wire

// ----- filelist.f -----
rtl/core/lsbp_pkg.sv
rtl/core/lsbp_if.sv
rtl/core/lsbp_front.sv
rtl/core/lsbp_queue.sv
rtl/core/lsbp_back.sv
rtl/core/lsb_first_code_symbol_packer_unit.sv
verif/lsb_first_code_symbol_packer_unit_test.sv
